// File: src/tcce_pkg.sv
// Constants and codes for the text console cursor engine.
// No dependencies; used by text_console_cursor_engine.
package tcce_pkg;

   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 32;

   localparam int COL_AW = $clog2(MAX_COLS);
   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int ADDR_W = COL_AW + ROW_AW;
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int NR_W   = $clog2(MAX_ROWS + 1);

   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [2:0] MODE_PUT_CUR = 3'd0;
   localparam logic [2:0] MODE_PUT_POS = 3'd1;
   localparam logic [2:0] MODE_GOTO    = 3'd2;
   localparam logic [2:0] MODE_BLANK   = 3'd3;
   localparam logic [2:0] MODE_CLEAR   = 3'd4;
   localparam logic [2:0] MODE_READ    = 3'd5;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   localparam logic [NC_W-1:0] COLS_RESET = NC_W'(80);
   localparam logic [NR_W-1:0] ROWS_RESET = NR_W'(25);

endpackage

// File: src/text_console_cursor_engine.sv
// Text console cursor engine: character grid in one synchronous memory plus cursor.
// Depends on tcce_pkg.
// Put without scroll, goto, blank and unused modes load their result into the output
// register, or a held one while it stalls; they run one item per cycle unless stalled.
// Read cell waits for memory data first. A put that scrolls walks the grid, copying each
// row up one row, then blanks the last row. Clear walks all MAX_COLS*MAX_ROWS = 4096 cells, one a cycle.
// Reset clears control state and starts the same clearing pass; no item and
// no register write is taken until it ends.
module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_mode,
   input  logic [7:0]        req_char_code,
   input  logic signed [8:0] req_x_pos,
   input  logic [6:0]        req_y_pos,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_cursor_col,
   output logic [4:0]        rsp_cursor_row,
   output logic [7:0]        rsp_cell_char,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RDWAIT, ST_SCROLL, ST_SDRAIN, ST_BLANK, ST_CLEAR
   } state_type;

   logic [CHAR_W-1:0] grid_mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   state_type          state_ff, state_in;
   logic [NC_W-1:0]    nc_ff, nc_in;
   logic [NR_W-1:0]    nr_ff, nr_in;
   logic [7:0]         cur_col_ff, cur_col_in;
   logic [ROW_AW-1:0]  cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               clr_push_ff, clr_push_in;
   logic [ROW_AW-1:0]  sr_ff, sr_in;
   logic [COL_AW-1:0]  cc_ff, cc_in;
   logic               cp_valid_ff, cp_valid_in;
   logic [ADDR_W-1:0]  cp_addr_ff, cp_addr_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_col_ff, out_col_in;
   logic [4:0]         out_row_ff, out_row_in;
   logic [7:0]         out_cell_ff, out_cell_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [7:0]         pend_col_ff, pend_col_in;
   logic [4:0]         pend_row_ff, pend_row_in;
   logic [7:0]         pend_cell_ff, pend_cell_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [CHAR_W-1:0]  mem_wd;
   logic [ADDR_W-1:0]  mem_ra;

   logic               accept;
   logic               push;
   logic [7:0]         res_cell;
   logic               out_free;

   logic               x_neg;
   logic [7:0]         x_mag;
   logic               pos_ok;
   logic               ch_storable;
   logic [ADDR_W-1:0]  pos_addr;
   logic [ADDR_W-1:0]  cur_addr;
   logic [NC_W-1:0]    nc_m1;
   logic [NR_W-1:0]    nr_m1;
   logic               wrap;
   logic               last_row;
   logic               cur_in_grid;
   logic [NR_W-1:0]    row_p1;

   assign req_ready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign x_neg       = req_x_pos[8];
   assign x_mag       = req_x_pos[7:0];
   assign pos_ok      = !x_neg && (x_mag < nc_ff) && (req_y_pos < {1'b0, nr_ff});
   assign ch_storable = (req_char_code != CH_CR) && (req_char_code != CH_LF);
   assign pos_addr    = {req_y_pos[ROW_AW-1:0], x_mag[COL_AW-1:0]};
   assign cur_addr    = {cur_row_ff, cur_col_ff[COL_AW-1:0]};
   assign nc_m1       = nc_ff - NC_W'(1);
   assign nr_m1       = nr_ff - NR_W'(1);
   assign row_p1      = {1'b0, cur_row_ff} + NR_W'(1);
   assign cur_in_grid = (cur_col_ff < nc_ff) && ({1'b0, cur_row_ff} < nr_ff);
   assign wrap        = (({1'b0, cur_col_ff} + 9'd1) >= {1'b0, nc_ff})
                        || (req_char_code == CH_LF);
   assign last_row    = row_p1 >= nr_ff;
   assign out_free    = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      nc_in       = nc_ff;
      nr_in       = nr_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_push_in = clr_push_ff;
      sr_in       = sr_ff;
      cc_in       = cc_ff;
      cp_valid_in = 1'b0;
      cp_addr_in  = cp_addr_ff;
      rd_ok_in    = rd_ok_ff;
      mem_we      = 1'b0;
      mem_wa      = cur_addr;
      mem_wd      = req_char_code;
      mem_ra      = pos_addr;
      push        = 1'b0;
      res_cell    = 8'd0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMNS: begin
               if (csr_data == 8'd0) begin
                  nc_in = NC_W'(1);
               end else if (32'(csr_data) > MAX_COLS) begin
                  nc_in = NC_W'(MAX_COLS);
               end else begin
                  nc_in = NC_W'(csr_data);
               end
            end
            CSR_ROWS: begin
               if (csr_data[5:0] == 6'd0) begin
                  nr_in = NR_W'(1);
               end else if (32'(csr_data[5:0]) > MAX_ROWS) begin
                  nr_in = NR_W'(MAX_ROWS);
               end else begin
                  nr_in = NR_W'(csr_data[5:0]);
               end
            end
            default: begin
            end
         endcase
      end

      if (cp_valid_ff) begin
         mem_we = 1'b1;
         mem_wa = cp_addr_ff;
         mem_wd = rd_data_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push = 1'b1;
               unique case (req_mode)
                  MODE_PUT_CUR: begin
                     mem_we = cur_in_grid && ch_storable;
                     mem_wa = cur_addr;
                     mem_wd = req_char_code;
                     if (wrap) begin
                        cur_col_in = 8'd0;
                        if (last_row) begin
                           cur_row_in = nr_m1[ROW_AW-1:0];
                           if (nr_ff > NR_W'(1)) begin
                              push     = 1'b0;
                              state_in = ST_SCROLL;
                              sr_in    = ROW_AW'(1);
                              cc_in    = '0;
                           end
                        end else begin
                           cur_row_in = row_p1[ROW_AW-1:0];
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 8'd1;
                     end
                  end
                  MODE_PUT_POS: begin
                     mem_we = pos_ok && ch_storable;
                     mem_wa = pos_addr;
                     mem_wd = req_char_code;
                  end
                  MODE_GOTO: begin
                     if (pos_ok) begin
                        cur_col_in = x_mag;
                        cur_row_in = req_y_pos[ROW_AW-1:0];
                     end else if ((req_x_pos == -9'sd1) && (req_y_pos != 7'd0)) begin
                        cur_col_in = 8'(nc_ff);
                        if (cur_row_ff != '0) begin
                           cur_row_in = cur_row_ff - ROW_AW'(1);
                        end
                     end else if (!x_neg && (x_mag >= nc_ff)
                                  && (({1'b0, req_y_pos} + 8'd1) < {2'b00, nr_ff})) begin
                        cur_col_in = 8'd0;
                        if (row_p1 < nr_ff) begin
                           cur_row_in = row_p1[ROW_AW-1:0];
                        end else begin
                           cur_row_in = nr_m1[ROW_AW-1:0];
                        end
                     end
                  end
                  MODE_BLANK: begin
                     mem_we = pos_ok;
                     mem_wa = pos_addr;
                     mem_wd = CH_SPACE;
                  end
                  MODE_CLEAR: begin
                     push        = 1'b0;
                     cur_col_in  = 8'd0;
                     cur_row_in  = '0;
                     clr_cnt_in  = '0;
                     clr_push_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  MODE_READ: begin
                     push     = 1'b0;
                     mem_ra   = pos_addr;
                     rd_ok_in = pos_ok;
                     state_in = ST_RDWAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            push     = 1'b1;
            res_cell = rd_ok_ff ? rd_data_ff : 8'd0;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            mem_ra      = {sr_ff, cc_ff};
            cp_valid_in = 1'b1;
            cp_addr_in  = {sr_ff - ROW_AW'(1), cc_ff};
            if (cc_ff == nc_m1[COL_AW-1:0]) begin
               cc_in = '0;
               if (sr_ff == nr_m1[ROW_AW-1:0]) begin
                  state_in = ST_SDRAIN;
               end else begin
                  sr_in = sr_ff + ROW_AW'(1);
               end
            end else begin
               cc_in = cc_ff + COL_AW'(1);
            end
         end
         ST_SDRAIN: begin
            state_in = ST_BLANK;
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            mem_wa = {nr_m1[ROW_AW-1:0], cc_ff};
            mem_wd = CH_SPACE;
            if (cc_ff == nc_m1[COL_AW-1:0]) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cc_in = cc_ff + COL_AW'(1);
            end
         end
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = CH_SPACE;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == '1) begin
               push        = clr_push_ff;
               clr_push_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_cell_in   = out_cell_ff;
      pend_valid_in = pend_valid_ff;
      pend_col_in   = pend_col_ff;
      pend_row_in   = pend_row_ff;
      pend_cell_in  = pend_cell_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_col_in    = pend_col_ff;
            out_row_in    = pend_row_ff;
            out_cell_in   = pend_cell_ff;
            pend_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_col_in   = cur_col_in;
            out_row_in   = 5'(cur_row_in);
            out_cell_in  = res_cell;
         end
      end else if (push) begin
         pend_valid_in = 1'b1;
         pend_col_in   = cur_col_in;
         pend_row_in   = 5'(cur_row_in);
         pend_cell_in  = res_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= grid_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_cell_ff  <= out_cell_in;
      pend_col_ff  <= pend_col_in;
      pend_row_ff  <= pend_row_in;
      pend_cell_ff <= pend_cell_in;
      cp_addr_ff   <= cp_addr_in;
      rd_ok_ff     <= rd_ok_in;
      sr_ff        <= sr_in;
      cc_ff        <= cc_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         nc_ff         <= COLS_RESET;
         nr_ff         <= ROWS_RESET;
         cur_col_ff    <= 8'd0;
         cur_row_ff    <= '0;
         clr_cnt_ff    <= '0;
         clr_push_ff   <= 1'b0;
         cp_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nc_ff         <= nc_in;
         nr_ff         <= nr_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_push_ff   <= clr_push_in;
         cp_valid_ff   <= cp_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cell_char  = out_cell_ff;

   a_pend_behind_out : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("held item without an item in the output register");

   a_read_waits : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_READ)) |=> (state_ff == ST_RDWAIT))
      else $error("read item did not wait for memory data");

   a_copy_in_walk : assert property (@(posedge clock) disable iff (reset)
      cp_valid_ff |-> ((state_ff == ST_SCROLL) || (state_ff == ST_SDRAIN)))
      else $error("row copy write outside the scroll walk");

   a_no_push_in_walk : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCROLL) || (state_ff == ST_SDRAIN)) |-> !push)
      else $error("result given before the scroll finished");

   a_csr_only_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_ready && !csr_ready))
      else $error("handshake open during the clearing pass");

endmodule
